>>> rtl/tnq_pkg.sv
// Package for the tone note queue player.
// Holds the queue sizing constants, the item and result structs, the FSM state
// type and the controller command struct. Depends on nothing.
package tnq_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_PUSH = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] note_freq;
        logic [31:0] note_duration;
        logic [31:0] time_now;
    } t_item;

    typedef struct packed {
        logic [15:0] tone_freq;
        logic        tone_active;
        logic        note_started;
        logic        note_ended;
        logic        push_dropped;
        logic [7:0]  notes_queued;
    } t_result;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_cmd;

endpackage

>>> rtl/tnq_ctrl.sv
// Controller for the tone note queue player.
// Sequences capture and execute of one item and times the result strobe.
// Depends on tnq_pkg.
module tnq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_strobe,
    output tnq_pkg::t_cmd o_cmd
);
    import tnq_pkg::*;

    t_state r_state, n_state;
    logic   r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= o_cmd.exec;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        busy          = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                busy       = 1'b1;
                o_cmd.exec = 1'b1;
                n_state    = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_strobe = r_strobe;

    a_strobe_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state == ST_EXEC))
        else $error("strobe without execute cycle");

    a_exec_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> $past(o_cmd.capture))
        else $error("execute without capture");

    a_no_capture_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.capture && o_cmd.exec))
        else $error("capture during execute");

endmodule

>>> rtl/tnq_dp.sv
// Datapath for the tone note queue player.
// Holds the note ring buffer memories, queue pointers, playback state and the
// result register. Depends on tnq_pkg.
module tnq_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tnq_pkg::t_cmd    i_cmd,
    input  tnq_pkg::t_item   i_item,
    output tnq_pkg::t_result o_result
);
    import tnq_pkg::*;

    logic [15:0]      mem_freq [QUEUE_DEPTH];
    logic [31:0]      mem_dur  [QUEUE_DEPTH];

    t_item            r_item;
    logic [15:0]      r_rd_freq;
    logic [31:0]      r_rd_dur;
    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_playing, n_playing;
    logic [31:0]      r_start, n_start;
    logic [15:0]      r_cur, n_cur;
    t_result          r_result, n_result;

    logic [IDX_W:0]   tail_sum;
    logic [IDX_W-1:0] tail;
    logic             full;
    logic             wr_en;
    logic [31:0]      elapsed;

    always_comb begin
        tail_sum = {1'b0, r_head} + (IDX_W+1)'(r_count);
        if (tail_sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
            tail = IDX_W'(tail_sum - (IDX_W+1)'(QUEUE_DEPTH));
        end else begin
            tail = tail_sum[IDX_W-1:0];
        end
        full    = (r_count == CNT_W'(QUEUE_DEPTH));
        elapsed = r_item.time_now - r_start;
        wr_en   = i_cmd.exec && (r_item.kind == KIND_PUSH) && !full;
    end

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_playing = r_playing;
        n_start   = r_start;
        n_cur     = r_cur;
        n_result  = '0;
        priority if (r_item.kind == KIND_PUSH) begin
            if (full) begin
                n_result.push_dropped = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (r_playing) begin
            if (elapsed > r_rd_dur) begin
                if (r_head == IDX_W'(QUEUE_DEPTH - 1)) begin
                    n_head = '0;
                end else begin
                    n_head = r_head + IDX_W'(1);
                end
                if (r_count != '0) begin
                    n_count = r_count - CNT_W'(1);
                end
                n_playing           = 1'b0;
                n_cur               = '0;
                n_result.note_ended = 1'b1;
            end
        end else begin
            if (r_count != '0) begin
                n_start               = r_item.time_now;
                n_playing             = 1'b1;
                n_cur                 = r_rd_freq;
                n_result.note_started = 1'b1;
            end
        end
        n_result.tone_freq    = n_cur;
        n_result.tone_active  = n_playing && (n_cur != '0);
        n_result.notes_queued = 8'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item    <= i_item;
            r_rd_freq <= mem_freq[r_head];
            r_rd_dur  <= mem_dur[r_head];
        end
        if (wr_en) begin
            mem_freq[tail] <= r_item.note_freq;
            mem_dur[tail]  <= r_item.note_duration;
        end
        if (i_cmd.exec) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_playing <= 1'b0;
            r_start   <= '0;
            r_cur     <= '0;
        end else if (i_cmd.exec) begin
            r_head    <= n_head;
            r_count   <= n_count;
            r_playing <= n_playing;
            r_start   <= n_start;
            r_cur     <= n_cur;
        end
    end

    assign o_result = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_playing_has_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing |-> (r_count != '0))
        else $error("playing with empty queue");

    a_silent_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_playing |-> (r_cur == '0))
        else $error("tone driven while no note plays");

    a_state_only_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_count) && $stable(r_head))
        else $error("queue pointers moved outside execute");

endmodule

>>> rtl/tone_note_queue_player.sv
// Top level of the tone note queue player.
// Joins the controller (tnq_ctrl) and the datapath (tnq_dp). Depends on tnq_pkg.
//
// An item is taken when start is high and busy is low. Each item is handled in
// order: first it is latched and the head note is read from the ring buffer
// memory, then the queue and playback state are updated. Its result appears on
// o_result for exactly one cycle, marked by o_strobe, in the cycle after the
// update, and a new item may be started in that same cycle; busy is high
// during the update. The receiver cannot stall; capture o_result whenever
// o_strobe is high. Every item, push or tick, gives exactly one result.
module tone_note_queue_player (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  tnq_pkg::t_item   i_item,
    output logic             busy,
    output logic             o_strobe,
    output tnq_pkg::t_result o_result
);
    import tnq_pkg::*;

    t_cmd cmd;

    tnq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (cmd)
    );

    tnq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule

>>> tb/tb_tone_note_queue_player.sv
// Self-checking testbench for tone_note_queue_player: directed and random note pushes
// and time ticks, checked against an in-bench prediction of the note queue and player.
// Depends on tnq_pkg and the tone_note_queue_player RTL.
module tb_tone_note_queue_player;
    import tnq_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 1000;

    class note_scoreboard;
        logic [15:0] freq_mem [QUEUE_DEPTH];
        logic [31:0] dur_mem  [QUEUE_DEPTH];
        int unsigned head_pos;
        int unsigned note_count;
        bit          playing;
        logic [31:0] play_start;
        logic [15:0] play_freq;
        t_result     pending [$];
        int unsigned errors;
        int unsigned n_push, n_tick, n_start, n_end, n_drop, n_results;

        function new();
            head_pos   = 0;
            note_count = 0;
            playing    = 1'b0;
            play_start = '0;
            play_freq  = '0;
            errors     = 0;
            n_push     = 0;
            n_tick     = 0;
            n_start    = 0;
            n_end      = 0;
            n_drop     = 0;
            n_results  = 0;
        endfunction

        function void report(string msg);
            $display("tb mismatch at %0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void note_item(t_item it);
            t_result     r;
            int unsigned slot;
            logic [31:0] elapsed;
            r = '0;
            if (it.kind == KIND_PUSH) begin
                n_push++;
                if (note_count < QUEUE_DEPTH) begin
                    slot = (head_pos + note_count) % QUEUE_DEPTH;
                    freq_mem[IDX_W'(slot)] = it.note_freq;
                    dur_mem[IDX_W'(slot)]  = it.note_duration;
                    note_count++;
                end else begin
                    r.push_dropped = 1'b1;
                    n_drop++;
                end
            end else begin
                n_tick++;
                if (playing) begin
                    elapsed = it.time_now - play_start;
                    if (elapsed > dur_mem[IDX_W'(head_pos)]) begin
                        head_pos = (head_pos + 1) % QUEUE_DEPTH;
                        if (note_count > 0)
                            note_count--;
                        playing      = 1'b0;
                        play_freq    = '0;
                        r.note_ended = 1'b1;
                        n_end++;
                    end
                end else if (note_count > 0) begin
                    play_start     = it.time_now;
                    playing        = 1'b1;
                    play_freq      = freq_mem[IDX_W'(head_pos)];
                    r.note_started = 1'b1;
                    n_start++;
                end
            end
            r.tone_freq    = play_freq;
            r.tone_active  = playing && (play_freq != 16'd0);
            r.notes_queued = 8'(note_count);
            pending.push_back(r);
        endfunction

        function void compare(string name, int unsigned exp, int unsigned got);
            if (exp != got)
                report($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                                 n_results, name, exp, got));
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (pending.size() == 0) begin
                report($sformatf("result 0x%0h with no item outstanding", got));
            end else begin
                exp = pending.pop_front();
                compare("tone_freq", 32'(exp.tone_freq), 32'(got.tone_freq));
                compare("tone_active", 32'(exp.tone_active), 32'(got.tone_active));
                compare("note_started", 32'(exp.note_started), 32'(got.note_started));
                compare("note_ended", 32'(exp.note_ended), 32'(got.note_ended));
                compare("push_dropped", 32'(exp.push_dropped), 32'(got.push_dropped));
                compare("notes_queued", 32'(exp.notes_queued), 32'(got.notes_queued));
            end
            n_results++;
        endfunction
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    t_item       i_item  = '0;
    logic        busy;
    logic        o_strobe;
    t_result     o_result;

    note_scoreboard sb = new();
    int unsigned    cycles = 0;
    logic [31:0]    sys_time = '0;
    bit             no_idle = 1'b0;

    tone_note_queue_player dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending.size());
            $display("tb_tone_note_queue_player: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result(o_result);
    end

    task automatic send_item(t_item it);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        sb.note_item(it);
    endtask

    task automatic send_push(logic [15:0] freq, logic [31:0] dur);
        t_item it;
        it.kind          = KIND_PUSH;
        it.note_freq     = freq;
        it.note_duration = dur;
        it.time_now      = $urandom;
        send_item(it);
    endtask

    task automatic send_tick(logic [31:0] advance);
        t_item it;
        sys_time         = sys_time + advance;
        it.kind          = KIND_TICK;
        it.note_freq     = 16'($urandom);
        it.note_duration = $urandom;
        it.time_now      = sys_time;
        send_item(it);
    endtask

    function automatic logic [15:0] rand_freq();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] rand_dur();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(0, 12);
        if (r < 9)
            return $urandom_range(0, 300);
        return $urandom;
    endfunction

    initial begin
        int unsigned rand_items;
        int unsigned burst_len;
        int unsigned mode;
        int unsigned push_pct;
        int unsigned guard;
        bit          first_burst;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sys_time = 32'hFFFF_FFF0;
        send_tick(0);
        send_push(16'hFFFF, 32'd0);
        send_push(16'h0000, 32'd3);
        send_push(16'h0001, 32'd5);
        send_tick(0);
        send_tick(0);
        send_tick(1);
        send_tick(0);
        send_tick(3);
        send_tick(1);
        send_tick(5);
        send_tick(6);
        send_tick(2);
        send_tick(0);

        rand_items  = 0;
        first_burst = 1'b1;
        while (rand_items < RANDOM_ITEMS) begin
            mode        = first_burst ? 0 : $urandom_range(0, 7);
            first_burst = 1'b0;
            no_idle     = ($urandom_range(0, 3) == 0);
            burst_len   = $urandom_range(20, 60);
            if (mode == 0) begin
                push_pct  = 100;
                burst_len = 140;
            end else if (mode <= 2) begin
                push_pct = 75;
            end else if (mode <= 5) begin
                push_pct = 45;
            end else begin
                push_pct = 20;
            end
            repeat (burst_len) begin
                if ($urandom_range(1, 100) <= push_pct) begin
                    send_push(rand_freq(), rand_dur());
                end else if ($urandom_range(0, 99) < 15) begin
                    send_tick($urandom);
                end else begin
                    send_tick($urandom_range(0, 6));
                end
                rand_items++;
            end
        end

        no_idle = 1'b0;
        guard   = 0;
        while (((sb.note_count != 0) || sb.playing) && (guard < 3000)) begin
            if (guard % 2)
                send_tick($urandom);
            else
                send_tick($urandom_range(1, 50));
            guard++;
        end

        send_push(16'hABCD, 32'hFFFF_FFFF);
        send_tick(1);
        send_push(rand_freq(), rand_dur());
        send_tick(32'hFFFF_FFFF);
        send_tick(32'd1);
        send_tick(32'h8000_0000);
        send_tick(32'h7FFF_FFFF);
        start <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("tb covered %0d transfers: %0d pushes (%0d refused on a full queue), %0d ticks",
                 sb.n_push + sb.n_tick, sb.n_push, sb.n_drop, sb.n_tick);
        $display("tb saw %0d note starts and %0d note ends over %0d checked results",
                 sb.n_start, sb.n_end, sb.n_results);
        if (sb.errors == 0) begin
            $display("tb_tone_note_queue_player: clean");
        end else begin
            $display("tb_tone_note_queue_player: errors");
        end
        $finish;
    end
endmodule

>>> tone_note_queue_player.f
rtl/tnq_pkg.sv
rtl/tnq_ctrl.sv
rtl/tnq_dp.sv
rtl/tone_note_queue_player.sv
tb/tb_tone_note_queue_player.sv
